// ===== hdl/bbd_pkg.sv =====
`default_nettype none
package bbd_pkg;

  localparam int PIX_W        = 16;
  localparam int COMP_W       = 8;
  localparam int CFG_W        = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int ROW_W        = 12;
  localparam int MAX_HEIGHT   = 4096;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

  // {row odd, column odd} of a BGGR site
  typedef enum logic [1:0] {
    SITE_BLUE    = 2'b00,
    SITE_GREEN_B = 2'b01,
    SITE_GREEN_R = 2'b10,
    SITE_RED     = 2'b11
  } site_e;

  typedef struct packed {
    site_e            site;
    logic             has_left;
    logic             has_right;
    logic             has_up;
    logic             has_down;
    logic [PIX_W-1:0] ctr;
    logic [PIX_W-1:0] lft;
    logic [PIX_W-1:0] rgt;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] upleft;
    logic [PIX_W-1:0] down;
    logic [PIX_W-1:0] downright;
  } nbhd_t;

  typedef struct packed {
    logic [COMP_W-1:0] blue;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] red;
  } rgb_t;

endpackage
`default_nettype wire

// ===== hdl/bbd_site_rules.sv =====
`default_nettype none
module bbd_site_rules
  import bbd_pkg::*;
(
  input  nbhd_t nb_i,
  output rgb_t  rgb_o
);

  logic [PIX_W-1:0] lv, rv, uv, dv;
  logic [PIX_W:0]   sum_rd, sum_lu;

  always_comb begin
    // missing edge neighbors fall back to the center sample
    lv = nb_i.has_left  ? nb_i.lft  : nb_i.ctr;
    rv = nb_i.has_right ? nb_i.rgt  : nb_i.ctr;
    uv = nb_i.has_up    ? nb_i.up   : nb_i.ctr;
    dv = nb_i.has_down  ? nb_i.down : nb_i.ctr;
    sum_rd = {1'b0, rv} + {1'b0, dv};
    sum_lu = {1'b0, lv} + {1'b0, uv};
    case (nb_i.site)
      SITE_BLUE: begin
        rgb_o.blue  = nb_i.ctr[PIX_W-1 -: COMP_W];
        rgb_o.green = sum_rd[PIX_W -: COMP_W];
        rgb_o.red   = (nb_i.has_right && nb_i.has_down) ?
                      nb_i.downright[PIX_W-1 -: COMP_W] : '0;
      end
      SITE_GREEN_B: begin
        rgb_o.green = nb_i.ctr[PIX_W-1 -: COMP_W];
        rgb_o.blue  = lv[PIX_W-1 -: COMP_W];
        rgb_o.red   = dv[PIX_W-1 -: COMP_W];
      end
      SITE_GREEN_R: begin
        rgb_o.green = nb_i.ctr[PIX_W-1 -: COMP_W];
        rgb_o.red   = lv[PIX_W-1 -: COMP_W];
        rgb_o.blue  = uv[PIX_W-1 -: COMP_W];
      end
      SITE_RED: begin
        rgb_o.red   = nb_i.ctr[PIX_W-1 -: COMP_W];
        rgb_o.green = sum_lu[PIX_W -: COMP_W];
        rgb_o.blue  = (nb_i.has_left && nb_i.has_up) ?
                      nb_i.upleft[PIX_W-1 -: COMP_W] : '0;
      end
      default: begin
        rgb_o = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/bayer_bggr_demosaic_core.sv =====
`default_nettype none
// BGGR Bayer to 8-bit RGB demosaic. Accepts one 16-bit sample per clock in raster
// order (tuser low) and returns RGB words one row and one column behind; the last
// sample of a row also returns the row's final pixel, so a word can yield two
// results. After the last row of a frame, each flush word (tuser high) returns
// one pixel of that row, tlast marking the frame's last pixel; a flush with
// nothing pending returns nothing and a sample ends any pending drain. Two line
// stores of MAX_WIDTH x 16 bits hold the previous two rows; each accepted word
// does at most one synchronous read per store and at most one write, so the
// sustained rate is one word per cycle while the output queue has room, with
// results registered in the second stage and then a four-deep output queue that
// absorbs downstream stalls. Line store contents need no clearing after reset. A
// configuration write restarts the frame and must only happen while the block is idle.
module bayer_bggr_demosaic_core
  import bbd_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [CFG_W-1:0]       cfg_data_i,
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire [PIX_W-1:0]       s_axis_tdata,   // [15:0] raw_pixel
  input  wire                   s_axis_tuser,   // [0] req_type (1 = flush)
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  output logic [3*COMP_W-1:0]   m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  output logic                  m_axis_tlast    // frame_last
);

  localparam int AW       = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW       = $clog2(MAX_WIDTH + 1);
  localparam int CMPW     = (WW > CFG_W) ? WW : CFG_W;
  localparam int WRST     = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;
  localparam int OQ_CW    = 3;

  typedef struct packed {
    rgb_t rgb;
    logic last;
  } out_word_t;

  // frame control
  logic [AW-1:0]    wlast_q, wlast_d;
  logic [ROW_W-1:0] hlast_q, hlast_d;
  logic [AW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             bank_sel_q, bank_sel_d;
  logic             drain_q, drain_d;
  logic [AW-1:0]    drain_col_q, drain_col_d;

  logic [CMPW-1:0]  cfg_wide;
  logic             in_acc, raw_acc, flush_go, s2_load, s2_fire, s2_go;
  logic [AW-1:0]    n_addr, o_addr, addr0, addr1;

  // line stores
  logic [PIX_W-1:0] bank0_mem [MAX_WIDTH];
  logic [PIX_W-1:0] bank1_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd0_q, rd1_q;

  // second stage
  logic             s2_valid_q, s2_valid_d;
  logic             s2_flush_q, s2_bank_q;
  logic [AW-1:0]    s2_x_q;
  logic [ROW_W-1:0] s2_y_q;
  logic [PIX_W-1:0] s2_pix_q, s2_prev_q;
  logic [PIX_W-1:0] prev_q, first0_q;
  logic [PIX_W-1:0] n1_q, n2_q, o1_q, o2_q;
  logic [PIX_W-1:0] mem_n, mem_o;
  nbhd_t            nb_a, nb_b;
  rgb_t             rgb_a, rgb_b;
  logic             push_a, push_b;
  out_word_t        word_a, word_b;

  // output queue
  out_word_t        oq_q [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [OQ_CW-1:0] cnt_q;
  logic [1:0]       n_push;
  logic             pop;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign raw_acc  = in_acc && !s_axis_tuser;
  assign flush_go = in_acc && s_axis_tuser && drain_q;
  assign s2_load  = raw_acc || flush_go;
  assign s2_go    = cnt_q < OQ_CW'(OQ_DEPTH - 1);
  assign s2_fire  = s2_valid_q && s2_go;
  assign s_axis_tready = !s2_valid_q || s2_go;

  // config clamp and frame counters
  always_comb begin
    cfg_wide    = CMPW'(cfg_data_i);
    wlast_d     = wlast_q;
    hlast_d     = hlast_q;
    col_d       = col_q;
    row_d       = row_q;
    bank_sel_d  = bank_sel_q;
    drain_d     = drain_q;
    drain_col_d = drain_col_q;
    if (cfg_we_i) begin
      if (cfg_index_i == CFG_IDX_WIDTH) begin
        if (cfg_data_i == '0) begin
          wlast_d = '0;
        end else if (cfg_wide > CMPW'(MAX_WIDTH)) begin
          wlast_d = AW'(MAX_WIDTH - 1);
        end else begin
          wlast_d = AW'(cfg_wide - CMPW'(1));
        end
      end
      if (cfg_index_i == CFG_IDX_HEIGHT) begin
        if (cfg_data_i == '0) begin
          hlast_d = '0;
        end else if (cfg_data_i > CFG_W'(MAX_HEIGHT)) begin
          hlast_d = ROW_W'(MAX_HEIGHT - 1);
        end else begin
          hlast_d = ROW_W'(cfg_data_i - CFG_W'(1));
        end
      end
      if (cfg_index_i == CFG_IDX_WIDTH || cfg_index_i == CFG_IDX_HEIGHT) begin
        col_d       = '0;
        row_d       = '0;
        drain_d     = 1'b0;
        drain_col_d = '0;
      end
    end else if (raw_acc) begin
      drain_d     = 1'b0;
      drain_col_d = '0;
      if (col_q == wlast_q) begin
        col_d      = '0;
        bank_sel_d = !bank_sel_q;
        if (row_q == hlast_q) begin
          row_d   = '0;
          drain_d = 1'b1;
        end else begin
          row_d = row_q + ROW_W'(1);
        end
      end else begin
        col_d = col_q + AW'(1);
      end
    end else if (flush_go) begin
      if (drain_col_q == wlast_q) begin
        drain_d     = 1'b0;
        drain_col_d = '0;
      end else begin
        drain_col_d = drain_col_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q     <= AW'(WRST - 1);
      hlast_q     <= ROW_W'(HEIGHT_RESET - 1);
      col_q       <= '0;
      row_q       <= '0;
      bank_sel_q  <= 1'b0;
      drain_q     <= 1'b0;
      drain_col_q <= '0;
    end else begin
      wlast_q     <= wlast_d;
      hlast_q     <= hlast_d;
      col_q       <= col_d;
      row_q       <= row_d;
      bank_sel_q  <= bank_sel_d;
      drain_q     <= drain_d;
      drain_col_q <= drain_col_d;
    end
  end

  // newer row is read one column ahead while draining
  always_comb begin
    if (s_axis_tuser) begin
      o_addr = drain_col_q;
      n_addr = (drain_col_q == wlast_q) ? drain_col_q : drain_col_q + AW'(1);
    end else begin
      o_addr = col_q;
      n_addr = col_q;
    end
    addr0 = bank_sel_q ? o_addr : n_addr;
    addr1 = bank_sel_q ? n_addr : o_addr;
  end

  // the older bank is read before it is overwritten at the same column
  always_ff @(posedge clk_i) begin
    if (raw_acc && bank_sel_q) begin
      bank0_mem[col_q] <= s_axis_tdata;
    end
    if (s2_load) begin
      rd0_q <= bank0_mem[addr0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (raw_acc && !bank_sel_q) begin
      bank1_mem[col_q] <= s_axis_tdata;
    end
    if (s2_load) begin
      rd1_q <= bank1_mem[addr1];
    end
  end

  // second stage registers
  always_comb begin
    s2_valid_d = s2_valid_q;
    if (s2_load) begin
      s2_valid_d = 1'b1;
    end else if (s2_go) begin
      s2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_flush_q <= s_axis_tuser;
      s2_bank_q  <= bank_sel_q;
      s2_x_q     <= s_axis_tuser ? drain_col_q : col_q;
      s2_y_q     <= s_axis_tuser ? hlast_q : row_q;
      s2_pix_q   <= s_axis_tdata;
      s2_prev_q  <= prev_q;
    end
    if (raw_acc) begin
      prev_q <= s_axis_tdata;
      if (col_q == '0) begin
        first0_q <= s_axis_tdata;
      end
    end
    // advance the neighbor windows of both rows
    if (s2_fire) begin
      n2_q <= nb_a.ctr;
      n1_q <= mem_n;
      o2_q <= o1_q;
      o1_q <= mem_o;
    end
  end

  assign mem_n = s2_bank_q ? rd1_q : rd0_q;
  assign mem_o = s2_bank_q ? rd0_q : rd1_q;

  always_comb begin
    nb_a.lft       = n2_q;
    nb_a.rgt       = mem_n;
    nb_a.downright = s2_pix_q;
    if (s2_flush_q) begin
      nb_a.site      = site_e'({s2_y_q[0], s2_x_q[0]});
      nb_a.ctr       = (s2_x_q == '0) ? first0_q : n1_q;
      nb_a.up        = mem_o;
      nb_a.upleft    = o1_q;
      nb_a.down      = s2_prev_q;
      nb_a.has_left  = s2_x_q != '0;
      nb_a.has_right = s2_x_q != wlast_q;
      nb_a.has_up    = s2_y_q != '0;
      nb_a.has_down  = 1'b0;
    end else begin
      nb_a.site      = site_e'({!s2_y_q[0], !s2_x_q[0]});
      nb_a.ctr       = n1_q;
      nb_a.up        = o1_q;
      nb_a.upleft    = o2_q;
      nb_a.down      = s2_prev_q;
      nb_a.has_left  = s2_x_q > AW'(1);
      nb_a.has_right = 1'b1;
      nb_a.has_up    = s2_y_q > ROW_W'(1);
      nb_a.has_down  = 1'b1;
    end

    // final pixel of the row above, only from the last sample of a row
    nb_b.site      = site_e'({!s2_y_q[0], wlast_q[0]});
    nb_b.ctr       = mem_n;
    nb_b.lft       = n1_q;
    nb_b.rgt       = mem_n;
    nb_b.up        = mem_o;
    nb_b.upleft    = o1_q;
    nb_b.down      = s2_pix_q;
    nb_b.downright = '0;
    nb_b.has_left  = wlast_q != '0;
    nb_b.has_right = 1'b0;
    nb_b.has_up    = s2_y_q > ROW_W'(1);
    nb_b.has_down  = 1'b1;

    push_a = s2_fire && (s2_flush_q || (s2_y_q != '0 && s2_x_q != '0));
    push_b = s2_fire && !s2_flush_q && s2_y_q != '0 && s2_x_q == wlast_q;
  end

  bbd_site_rules u_rules_a (
    .nb_i  (nb_a),
    .rgb_o (rgb_a)
  );

  bbd_site_rules u_rules_b (
    .nb_i  (nb_b),
    .rgb_o (rgb_b)
  );

  assign word_a.rgb  = rgb_a;
  assign word_a.last = s2_flush_q && (s2_x_q == wlast_q);
  assign word_b.rgb  = rgb_b;
  assign word_b.last = 1'b0;

  // output queue
  assign n_push = {1'b0, push_a} + {1'b0, push_b};
  assign pop    = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (push_a || push_b) begin
      oq_q[wr_ptr_q] <= push_a ? word_a : word_b;
    end
    if (push_a && push_b) begin
      oq_q[wr_ptr_q + OQ_AW'(1)] <= word_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + OQ_AW'(n_push);
      rd_ptr_q <= rd_ptr_q + OQ_AW'(pop);
      cnt_q    <= cnt_q + OQ_CW'(n_push) - OQ_CW'(pop);
    end
  end

  assign m_axis_tvalid = cnt_q != '0;
  assign m_axis_tdata  = {oq_q[rd_ptr_q].rgb.blue, oq_q[rd_ptr_q].rgb.green,
                          oq_q[rd_ptr_q].rgb.red};
  assign m_axis_tlast  = oq_q[rd_ptr_q].last;

`ifndef SYNTH
  a_oq_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OQ_CW'(OQ_DEPTH))
    else $error("output queue overflow");

  a_col_in_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= wlast_q && drain_col_q <= wlast_q)
    else $error("column counter beyond row width");

  a_drain_at_frame_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> (col_q == '0 && row_q == '0))
    else $error("drain pending outside frame start");

  a_raw_reaches_s2 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> s2_valid_q)
    else $error("accepted sample lost before second stage");

  a_two_pushes_fit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_a && push_b) |-> cnt_q <= OQ_CW'(OQ_DEPTH - 2))
    else $error("double push without room");
`endif

endmodule
`default_nettype wire
